// ===== hdl/pfb_pkg.sv =====
`timescale 1ns / 1ps

package pfb_pkg;

    // Field widths of the bus and pixel transactions.
    localparam int OP_W     = 2;
    localparam int OFS_W    = 21;
    localparam int DATA_W   = 32;
    localparam int COLOR_W  = 24;
    localparam int PAL_AW   = 8;
    localparam int PAL_DEPTH = 256;
    localparam int MODE_W   = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd3;

    // Register word offsets.
    localparam logic [OFS_W-1:0] OFS_MODE     = 21'h080000;
    localparam logic [OFS_W-1:0] OFS_VBL_CTL  = 21'h080002;
    localparam logic [OFS_W-1:0] OFS_VBL_ACK  = 21'h080005;
    localparam logic [OFS_W-1:0] OFS_STATUS   = 21'h080008;
    localparam logic [OFS_W-1:0] OFS_DAC_IDX  = 21'h100000;
    localparam logic [OFS_W-1:0] OFS_DAC_DATA = 21'h100001;

    localparam logic [DATA_W-1:0] VBL_ENABLE_WORD = 32'hdcef0000;

    // Top-byte codes of the mode register.
    localparam logic [7:0] CODE_1BPP  = 8'hfb;
    localparam logic [7:0] CODE_2BPP  = 8'hfa;
    localparam logic [7:0] CODE_4BPP  = 8'hf9;
    localparam logic [7:0] CODE_8BPP  = 8'hf8;
    localparam logic [7:0] CODE_24BPP = 8'hff;

    // Internal pixel mode encoding.
    localparam logic [MODE_W-1:0] MODE_1BPP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_2BPP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_4BPP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_8BPP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_24BPP = 3'd4;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hffffff;

    // Output queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Side information that travels with a palette read.
    typedef struct packed {
        logic               use_pal;
        logic [COLOR_W-1:0] color;
        logic               status_bit;
        logic               irq;
        logic               last;
    } meta_t;

    typedef struct packed {
        logic              valid;
        logic [PAL_AW-1:0] rd_addr;
        meta_t             meta;
    } issue_t;

    typedef struct packed {
        logic               en;
        logic [PAL_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } pal_wr_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               irq;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } result_t;

endpackage

// ===== hdl/pfb_in_if.sv =====
`timescale 1ns / 1ps

interface pfb_in_if import pfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [OFS_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pixel_word;

    modport source (output valid, output operation, output reg_offset,
                    output write_data, output pixel_word, input ready);
    modport sink   (input valid, input operation, input reg_offset,
                    input write_data, input pixel_word, output ready);
endinterface

// ===== hdl/pfb_out_if.sv =====
`timescale 1ns / 1ps

interface pfb_out_if import pfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_data;
    logic               irq;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;

    modport source (output valid, output read_data, output irq,
                    output pixel_color, output last, input ready);
    modport sink   (input valid, input read_data, input irq,
                    input pixel_color, input last, output ready);
endinterface

// ===== hdl/pfb_palette.sv =====
`timescale 1ns / 1ps

module pfb_palette import pfb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  pal_wr_t            wr,
    input  logic [PAL_AW-1:0]  rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0]   mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] written_reg;
    logic [COLOR_W-1:0]   q_reg;
    logic                 q_written_reg;
    logic                 q_zero_reg;

    // Entries never written since reset read as their reset color.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr.en)
        begin
            written_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        q_reg         <= mem[rd_addr];
        q_written_reg <= written_reg[rd_addr];
        q_zero_reg    <= (rd_addr == '0);
    end

    assign rd_data = q_written_reg ? q_reg : (q_zero_reg ? COLOR_WHITE : '0);

endmodule

// ===== hdl/pfb_ctrl.sv =====
`timescale 1ns / 1ps

module pfb_ctrl import pfb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pfb_in_if.sink    in_ch,
    input  logic      room,
    output issue_t    issue,
    output pal_wr_t   pal_wr
);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [7:0]        index_reg, index_next;
    logic [1:0]        bcount_reg, bcount_next;
    logic [7:0]        pend0_reg, pend0_next;
    logic [7:0]        pend1_reg, pend1_next;
    logic              vbl_dis_reg, vbl_dis_next;
    logic              toggle_reg, toggle_next;
    logic              irq_reg, irq_next;
    logic              exp_reg, exp_next;
    logic [2:0]        remain_reg, remain_next;
    logic [7:0]        shift_reg, shift_next;

    logic       accept;
    logic [7:0] top;
    logic [7:0] pbyte;

    function automatic logic [PAL_AW-1:0] pick_index(input logic [7:0] b,
                                                     input logic [MODE_W-1:0] m);
        logic [PAL_AW-1:0] r;
        begin
            case (m)
                MODE_1BPP: r = {7'd0, b[7]};
                MODE_2BPP: r = {6'd0, b[7:6]};
                MODE_4BPP: r = {4'd0, b[7:4]};
                default:   r = b;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] advance(input logic [7:0] b,
                                           input logic [MODE_W-1:0] m);
        logic [7:0] r;
        begin
            case (m)
                MODE_1BPP: r = {b[6:0], 1'b0};
                MODE_2BPP: r = {b[5:0], 2'b0};
                MODE_4BPP: r = {b[3:0], 4'b0};
                default:   r = 8'd0;
            endcase
            return r;
        end
    endfunction

    assign in_ch.ready = room && !exp_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign top         = in_ch.write_data[DATA_W-1:DATA_W-8];
    assign pbyte       = in_ch.pixel_word[7:0];

    always_comb
    begin
        mode_next    = mode_reg;
        index_next   = index_reg;
        bcount_next  = bcount_reg;
        pend0_next   = pend0_reg;
        pend1_next   = pend1_reg;
        vbl_dis_next = vbl_dis_reg;
        toggle_next  = toggle_reg;
        irq_next     = irq_reg;
        exp_next     = exp_reg;
        remain_next  = remain_reg;
        shift_next   = shift_reg;

        pal_wr         = '0;
        issue          = '0;
        issue.meta.last = 1'b1;

        if (exp_reg)
        begin
            // Remaining pixels of a fetched byte, one palette read per cycle while there is room.
            if (room)
            begin
                issue.valid        = 1'b1;
                issue.rd_addr      = pick_index(shift_reg, mode_reg);
                issue.meta.use_pal = 1'b1;
                issue.meta.irq     = irq_reg;
                issue.meta.last    = (remain_reg == 3'd1);
                shift_next         = advance(shift_reg, mode_reg);
                remain_next        = remain_reg - 3'd1;
                exp_next           = (remain_reg != 3'd1);
            end
        end
        else if (accept)
        begin
            issue.valid = 1'b1;
            case (in_ch.operation)
                OP_WRITE:
                begin
                    case (in_ch.reg_offset)
                        OFS_MODE:
                        begin
                            case (top)
                                CODE_1BPP:  mode_next = MODE_1BPP;
                                CODE_2BPP:  mode_next = MODE_2BPP;
                                CODE_4BPP:  mode_next = MODE_4BPP;
                                CODE_8BPP:  mode_next = MODE_8BPP;
                                CODE_24BPP: mode_next = MODE_24BPP;
                                default:    mode_next = mode_reg;
                            endcase
                        end
                        OFS_VBL_ACK:
                        begin
                            irq_next = 1'b0;
                        end
                        OFS_DAC_IDX:
                        begin
                            index_next  = in_ch.write_data[7:0];
                            bcount_next = 2'd0;
                        end
                        OFS_DAC_DATA:
                        begin
                            if (bcount_reg >= 2'd2)
                            begin
                                pal_wr.en   = 1'b1;
                                pal_wr.addr = index_reg;
                                pal_wr.data = {pend0_reg, pend1_reg, top};
                                index_next  = index_reg + 8'd1;
                                bcount_next = 2'd0;
                            end
                            else
                            begin
                                if (bcount_reg[0])
                                begin
                                    pend1_next = top;
                                end
                                else
                                begin
                                    pend0_next = top;
                                end
                                bcount_next = bcount_reg + 2'd1;
                            end
                        end
                        OFS_VBL_CTL:
                        begin
                            if (in_ch.write_data == VBL_ENABLE_WORD)
                            begin
                                vbl_dis_next = 1'b0;
                                irq_next     = 1'b0;
                            end
                            else
                            begin
                                vbl_dis_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            irq_next = irq_reg;
                        end
                    endcase
                end
                OP_READ:
                begin
                    if (in_ch.reg_offset == OFS_STATUS)
                    begin
                        toggle_next            = !toggle_reg;
                        issue.meta.status_bit  = !toggle_reg;
                    end
                end
                OP_TICK:
                begin
                    if (!vbl_dis_reg)
                    begin
                        irq_next = 1'b1;
                    end
                end
                default:
                begin
                    case (mode_reg)
                        MODE_1BPP, MODE_2BPP, MODE_4BPP, MODE_8BPP:
                        begin
                            issue.rd_addr      = pick_index(pbyte, mode_reg);
                            issue.meta.use_pal = 1'b1;
                            shift_next         = advance(pbyte, mode_reg);
                            case (mode_reg)
                                MODE_1BPP: remain_next = 3'd7;
                                MODE_2BPP: remain_next = 3'd3;
                                MODE_4BPP: remain_next = 3'd1;
                                default:   remain_next = 3'd0;
                            endcase
                            exp_next        = (mode_reg != MODE_8BPP);
                            issue.meta.last = (mode_reg == MODE_8BPP);
                        end
                        default:
                        begin
                            // Direct color; the top byte of the word is dropped.
                            issue.meta.color = in_ch.pixel_word[COLOR_W-1:0];
                        end
                    endcase
                end
            endcase
            issue.meta.irq = irq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_1BPP;
            index_reg   <= '0;
            bcount_reg  <= '0;
            pend0_reg   <= '0;
            pend1_reg   <= '0;
            vbl_dis_reg <= 1'b1;
            toggle_reg  <= 1'b0;
            irq_reg     <= 1'b0;
            exp_reg     <= 1'b0;
            remain_reg  <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            index_reg   <= index_next;
            bcount_reg  <= bcount_next;
            pend0_reg   <= pend0_next;
            pend1_reg   <= pend1_next;
            vbl_dis_reg <= vbl_dis_next;
            toggle_reg  <= toggle_next;
            irq_reg     <= irq_next;
            exp_reg     <= exp_next;
            remain_reg  <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // A new transaction is never taken while a byte is still being expanded.
    assert property (@(posedge clk) disable iff (!rst_n) exp_reg |-> !in_ch.ready)
        else $error("input accepted during pixel expansion");
    // The color loader never leaves a partial count of three.
    assert property (@(posedge clk) disable iff (!rst_n) bcount_reg != 2'd3)
        else $error("palette byte count out of range");
    // An expansion always ends once its last pixel, marked last, is issued.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (exp_reg && room && remain_reg == 3'd1) |=> !exp_reg)
        else $error("expansion did not finish");

endmodule

// ===== hdl/pfb_outq.sv =====
`timescale 1ns / 1ps

module pfb_outq import pfb_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  result_t        push_data,
    pfb_out_if.source      out_ch,
    output logic [OQ_CW-1:0] count
);

    result_t            mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   wp_reg, wp_next;
    logic [OQ_AW-1:0]   rp_reg, rp_next;
    logic [OQ_CW-1:0]   count_reg, count_next;
    logic               pop;
    result_t            head;

    assign head               = mem[rp_reg];
    assign out_ch.valid       = (count_reg != '0);
    assign out_ch.read_data   = head.read_data;
    assign out_ch.irq         = head.irq;
    assign out_ch.pixel_color = head.pixel_color;
    assign out_ch.last        = head.last;
    assign pop                = out_ch.valid && out_ch.ready;
    assign count              = count_reg;

    always_comb
    begin
        wp_next    = push ? wp_reg + OQ_AW'(1) : wp_reg;
        rp_next    = pop ? rp_reg + OQ_AW'(1) : rp_reg;
        count_next = count_reg + OQ_CW'(push) - OQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= OQ_CW'(OQ_DEPTH))
        else $error("output queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
                     push && count_reg == OQ_CW'(OQ_DEPTH) |-> pop)
        else $error("push into a full output queue");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> count_reg == $past(count_reg) + OQ_CW'(1))
        else $error("output queue count mismatch");

endmodule

// ===== hdl/palette_framebuffer_registers.sv =====
`timescale 1ns / 1ps
// A first result passes the s1 register and the output queue after its input is taken.
// Throughput: one result per cycle while the output queue has room; a pixel transaction
// holds the input for 8, 4, 2 or 1 palette reads in 1, 2, 4 and 8 bpp, set by the single
// read port of the palette RAM. Register, tick and 24 bpp transactions are taken one per
// cycle while the queue has room. Reset (rst_n, asynchronous, active low) clears all control
// state and the per-entry written flags of the palette, so entry 0 reads white, the others black.

module palette_framebuffer_registers import pfb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pfb_in_if.sink     in_ch,
    pfb_out_if.source  out_ch
);

    // The controller decodes each transaction, keeps the register state and
    // issues at most one palette read per cycle. Side information for that read
    // waits in the s1 stage register while the RAM returns its data, then the
    // finished result enters a small output queue that decouples back-pressure.

    issue_t           issue;
    pal_wr_t          pal_wr;
    logic [COLOR_W-1:0] pal_data;
    logic             room;
    logic [OQ_CW-1:0] q_count;
    logic [OQ_CW-1:0] pending;

    logic             s1_valid_reg, s1_valid_next;
    meta_t            s1_meta_reg;
    result_t          s1_result;

    // Issue only when the queue can hold everything already in flight plus the
    // new result, so a stalled output never drops a transaction.
    assign pending = q_count + OQ_CW'(s1_valid_reg);
    assign room    = (pending < OQ_CW'(OQ_DEPTH));

    pfb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .room   (room),
        .issue  (issue),
        .pal_wr (pal_wr)
    );

    pfb_palette u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (pal_wr),
        .rd_addr (issue.rd_addr),
        .rd_data (pal_data)
    );

    assign s1_valid_next = issue.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_meta_reg <= issue.meta;
    end

    always_comb
    begin
        s1_result.read_data   = {29'd0, s1_meta_reg.status_bit, 2'd0};
        s1_result.irq         = s1_meta_reg.irq;
        s1_result.pixel_color = s1_meta_reg.use_pal ? pal_data : s1_meta_reg.color;
        s1_result.last        = s1_meta_reg.last;
    end

    pfb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .out_ch    (out_ch),
        .count     (q_count)
    );

    // Every issued read reaches the output stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) issue.valid |=> s1_valid_reg)
        else $error("issued read lost before the output stage");
    // The queue always has space for the result leaving the s1 stage.
    assert property (@(posedge clk) disable iff (!rst_n)
                     s1_valid_reg |-> q_count < OQ_CW'(OQ_DEPTH))
        else $error("s1 result with no queue space");
    // Nothing is issued while the queue lacks room.
    assert property (@(posedge clk) disable iff (!rst_n) !room |-> !issue.valid)
        else $error("issue without queue room");

endmodule
